// ===== design/vrte_pkg.sv =====
// shared constants, payload types and control structs for the rectangle transfer engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package vrte_pkg;

  localparam int unsigned STORE_WIDTH  = 1024;
  localparam int unsigned STORE_HEIGHT = 512;
  localparam int unsigned DEPTH        = STORE_WIDTH * STORE_HEIGHT;
  localparam int unsigned ADDR_W       = $clog2(DEPTH);

  localparam int unsigned COORD_W = 16;
  localparam int unsigned POS_W   = COORD_W + 1;
  localparam int unsigned COL_W   = 11;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned PIX_W   = 16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STORE = 2'd1,
    OP_MOVE  = 2'd2,
    OP_STEP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_STORE = 2'd2,
    KIND_MOVE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]                 operation;
    logic signed [COORD_W-1:0]  rect_x;
    logic signed [COORD_W-1:0]  rect_y;
    logic [COL_W-1:0]           rect_w;
    logic [ROW_W-1:0]           rect_h;
    logic signed [COORD_W-1:0]  dest_x;
    logic signed [COORD_W-1:0]  dest_y;
    logic [PIX_W-1:0]           pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last;
    logic             status;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic calc;
    logic addr;
  } walk_ctl_t;

  typedef struct packed {
    kind_e             kind;
    logic              last;
    logic              src_in;
    logic              dst_in;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
  } walk_info_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== design/vram_rect_transfer_engine.sv =====
// sequence: a start beat, or a step with no transfer open, goes from idle straight to done;
//   any other step passes the calc, address and memory states, and for a store or move the
//   read state, before done; one beat in flight, held in done until the output register is free
// reset: control clears at once, then a zeroing sweep of all 524288 pixels (one pixel a cycle)
//   runs through the pixel store with in_stall_o held high
// depends on vrte_pkg, vrte_walker and vrte_pixel_ram
`timescale 1ns / 1ps
`default_nettype none

module vram_rect_transfer_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire vrte_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output vrte_pkg::out_item_t      out_data_o
);
  import vrte_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CALC = 6'b000010,
    S_ADDR = 6'b000100,
    S_MEM  = 6'b001000,
    S_RD   = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  kind_e            kind_q, kind_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  out_item_t        res_q, res_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  walk_ctl_t        walk_ctl;
  walk_info_t       walk_info;
  ram_req_t         ram_req;
  logic [PIX_W-1:0] ram_rdata;
  logic             clearing;
  logic             in_acc;
  logic             out_free;

  vrte_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (walk_ctl),
    .item_i (in_data_i),
    .info_o (walk_info)
  );

  vrte_pixel_ram u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ram_req),
    .rdata_o    (ram_rdata),
    .clearing_o (clearing)
  );

  assign in_stall_o = (state_q != S_IDLE) || clearing;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    pix_d       = pix_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    walk_ctl    = '0;
    ram_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d = walk_info.kind;
          pix_d  = in_data_i.pixel_in;
          res_d  = '0;
          if (op_e'(in_data_i.operation) != OP_STEP) begin
            walk_ctl.start = 1'b1;
            res_d.last     = (in_data_i.rect_w == '0) || (in_data_i.rect_h == '0);
            state_d        = S_DONE;
          end else if (walk_info.kind == KIND_NONE) begin
            res_d.status = 1'b1;
            state_d      = S_DONE;
          end else begin
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        walk_ctl.calc = 1'b1;
        state_d       = S_ADDR;
      end
      S_ADDR: begin
        walk_ctl.addr = 1'b1;
        state_d       = S_MEM;
      end
      S_MEM: begin
        res_d.last = walk_info.last;
        case (kind_q)
          KIND_LOAD: begin
            ram_req.we    = walk_info.src_in;
            ram_req.waddr = walk_info.src_addr;
            ram_req.wdata = pix_q;
            state_d       = S_DONE;
          end
          KIND_STORE: begin
            ram_req.re    = walk_info.src_in;
            ram_req.raddr = walk_info.src_addr;
            state_d       = S_RD;
          end
          KIND_MOVE: begin
            ram_req.re    = walk_info.src_in && walk_info.dst_in;
            ram_req.raddr = walk_info.src_addr;
            state_d       = S_RD;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_RD: begin
        if (kind_q == KIND_STORE) begin
          res_d.pixel_out = walk_info.src_in ? ram_rdata : '0;
        end else begin
          ram_req.we    = walk_info.src_in && walk_info.dst_in;
          ram_req.waddr = walk_info.dst_addr;
          ram_req.wdata = ram_rdata;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // result waits here until the output register is free
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    pix_q  <= pix_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_write_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !ram_req.we
  ) else $error("pixel store written during zeroing sweep");

  a_read_then_rd : assert property (
    @(posedge clk_i) disable iff (!rst_ni) ram_req.re |=> (state_q == S_RD)
  ) else $error("read data not consumed in the following cycle");

  a_ignored_not_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> !(out_data_o.status && out_data_o.last)
  ) else $error("ignored step beat marked last");

  a_pixel_only_store : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_DONE) && (res_q.pixel_out != '0) |-> (kind_q == KIND_STORE)
  ) else $error("non-zero pixel on a result that is not a store step");

endmodule

`default_nettype wire

// ===== design/vrte_pixel_ram.sv =====
// pixel store: single write port, single registered read port, zeroing sweep after reset
// depends on vrte_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrte_pixel_ram (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire vrte_pkg::ram_req_t       req_i,
  output logic [vrte_pkg::PIX_W-1:0]    rdata_o,
  output logic                          clearing_o
);
  import vrte_pkg::*;

  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rdata_q;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              clr_q, clr_d;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_q;

endmodule

`default_nettype wire

// ===== design/vrte_walker.sv =====
// transfer context: rectangle origin, size, raster counters and per-pixel address stage
// depends on vrte_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrte_walker (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire vrte_pkg::walk_ctl_t    ctl_i,
  input  wire vrte_pkg::in_item_t     item_i,
  output vrte_pkg::walk_info_t        info_o
);
  import vrte_pkg::*;

  kind_e                     kind_q, kind_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic signed [COORD_W-1:0] org_x_q, org_y_q, tgt_x_q, tgt_y_q;
  logic [COL_W-1:0]          span_w_q;
  logic [ROW_W-1:0]          span_h_q;
  logic signed [POS_W-1:0]   sx_q, sy_q, dx_q, dy_q;
  logic                      last_q, last_d;
  logic                      src_in_q, dst_in_q;
  logic [ADDR_W-1:0]         src_addr_q, dst_addr_q;

  logic [COL_W:0]            col_inc;
  logic [ROW_W:0]            row_inc;
  logic                      col_wrap, row_wrap;
  logic signed [POS_W-1:0]   col_pos, row_pos;

  function automatic logic in_store(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
    return (x >= 0) && (x < $signed(POS_W'(STORE_WIDTH)))
        && (y >= 0) && (y < $signed(POS_W'(STORE_HEIGHT)));
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(logic signed [POS_W-1:0] x,
                                                logic signed [POS_W-1:0] y);
    return ADDR_W'($unsigned(y)) * ADDR_W'(STORE_WIDTH) + ADDR_W'($unsigned(x));
  endfunction

  assign col_inc  = {1'b0, col_q} + (COL_W + 1)'(1);
  assign row_inc  = {1'b0, row_q} + (ROW_W + 1)'(1);
  assign col_wrap = col_inc >= {1'b0, span_w_q};
  assign row_wrap = row_inc >= {1'b0, span_h_q};
  assign col_pos  = POS_W'($signed({1'b0, col_q}));
  assign row_pos  = POS_W'($signed({1'b0, row_q}));

  always_comb begin
    kind_d = kind_q;
    col_d  = col_q;
    row_d  = row_q;
    last_d = last_q;
    if (ctl_i.start) begin
      col_d = '0;
      row_d = '0;
      if (item_i.rect_w == '0 || item_i.rect_h == '0) begin
        kind_d = KIND_NONE;
      end else begin
        kind_d = kind_e'(item_i.operation + 2'd1);
      end
    end else if (ctl_i.calc) begin
      last_d = col_wrap && row_wrap;
      if (col_wrap) begin
        col_d = '0;
        if (row_wrap) begin
          row_d  = '0;
          kind_d = KIND_NONE;
        end else begin
          row_d = row_inc[ROW_W-1:0];
        end
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_NONE;
      col_q  <= '0;
      row_q  <= '0;
      last_q <= 1'b0;
    end else begin
      kind_q <= kind_d;
      col_q  <= col_d;
      row_q  <= row_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      org_x_q  <= item_i.rect_x;
      org_y_q  <= item_i.rect_y;
      tgt_x_q  <= item_i.dest_x;
      tgt_y_q  <= item_i.dest_y;
      span_w_q <= item_i.rect_w;
      span_h_q <= item_i.rect_h;
    end
    // exact signed positions of the current pixel, taken before the counters move
    if (ctl_i.calc) begin
      sx_q <= POS_W'(org_x_q) + col_pos;
      sy_q <= POS_W'(org_y_q) + row_pos;
      dx_q <= POS_W'(tgt_x_q) + col_pos;
      dy_q <= POS_W'(tgt_y_q) + row_pos;
    end
    if (ctl_i.addr) begin
      src_in_q   <= in_store(sx_q, sy_q);
      dst_in_q   <= in_store(dx_q, dy_q);
      src_addr_q <= to_addr(sx_q, sy_q);
      dst_addr_q <= to_addr(dx_q, dy_q);
    end
  end

  assign info_o.kind     = kind_q;
  assign info_o.last     = last_q;
  assign info_o.src_in   = src_in_q;
  assign info_o.dst_in   = dst_in_q;
  assign info_o.src_addr = src_addr_q;
  assign info_o.dst_addr = dst_addr_q;

endmodule

`default_nettype wire

// ===== bench/tb_vram_rect_transfer_engine.sv =====
// testbench for vram_rect_transfer_engine: directed and random rectangle transfers
// with a pixel store predictor and in-order result checking; depends on vrte_pkg
`timescale 1ns / 1ps

module tb_vram_rect_transfer_engine;
  import vrte_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1850;
  localparam int unsigned WATCHDOG_LIMIT = 2200000;
  localparam int unsigned SETTLE_CYCLES  = 16;

  // predictor of the pixel store and the open transfer, plus the queue of awaited results
  class pixel_scoreboard;
    bit [PIX_W-1:0] frame [DEPTH];
    kind_e          kind = KIND_NONE;
    int             org_x, org_y, dst_x, dst_y;
    int unsigned    span_w, span_h, col, row;
    out_item_t      expected_q[$];
    int unsigned    errors;

    function bit on_frame(input int x, input int y);
      return x >= 0 && x < int'(STORE_WIDTH) && y >= 0 && y < int'(STORE_HEIGHT);
    endfunction

    function int frame_addr(input int x, input int y);
      return y * int'(STORE_WIDTH) + x;
    endfunction

    // returns 0 for a step that finds no transfer open
    function bit note_beat(input in_item_t beat);
      out_item_t res;
      int        sx, sy, dx, dy;
      bit        acted;
      res   = '0;
      acted = 1'b1;
      if (op_e'(beat.operation) != OP_STEP) begin
        org_x  = int'($signed(beat.rect_x));
        org_y  = int'($signed(beat.rect_y));
        dst_x  = int'($signed(beat.dest_x));
        dst_y  = int'($signed(beat.dest_y));
        span_w = 32'(beat.rect_w);
        span_h = 32'(beat.rect_h);
        col    = 0;
        row    = 0;
        if (span_w == 0 || span_h == 0) begin
          kind     = KIND_NONE;
          res.last = 1'b1;
        end else begin
          case (op_e'(beat.operation))
            OP_LOAD:  kind = KIND_LOAD;
            OP_STORE: kind = KIND_STORE;
            default:  kind = KIND_MOVE;
          endcase
        end
      end else if (kind == KIND_NONE) begin
        res.status = 1'b1;
        acted      = 1'b0;
      end else begin
        sx = org_x + int'(col);
        sy = org_y + int'(row);
        case (kind)
          KIND_LOAD: begin
            if (on_frame(sx, sy)) frame[frame_addr(sx, sy)] = beat.pixel_in;
          end
          KIND_STORE: begin
            if (on_frame(sx, sy)) res.pixel_out = frame[frame_addr(sx, sy)];
          end
          default: begin
            dx = dst_x + int'(col);
            dy = dst_y + int'(row);
            if (on_frame(sx, sy) && on_frame(dx, dy))
              frame[frame_addr(dx, dy)] = frame[frame_addr(sx, sy)];
          end
        endcase
        col++;
        if (col >= span_w) begin
          col = 0;
          row++;
          if (row >= span_h) begin
            row      = 0;
            kind     = KIND_NONE;
            res.last = 1'b1;
          end
        end
      end
      expected_q.push_back(res);
      return acted;
    endfunction

    function void check_beat(input out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing awaited: pixel_out %h last %b status %b",
               got.pixel_out, got.last, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $error("pixel_out mismatch: expected %h, actual %h", want.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %b, actual %b", want.last, got.last);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %b, actual %b", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  pixel_scoreboard sb = new;
  int unsigned     items_done;
  int unsigned     burst_left;

  vram_rect_transfer_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver stall pattern: modes held for random stretches
  int unsigned stall_mode;
  int unsigned stall_left;
  int unsigned stall_phase;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    stall_phase = (stall_phase + 1) % 5;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_phase < 2);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_beat(out_data_o);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // sender works in bursts, sometimes long ones, with gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_beat(input in_item_t beat);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (sb.note_beat(beat)) items_done++;
    pace();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  function automatic in_item_t random_beat();
    in_item_t b;
    b.operation = 2'($urandom_range(0, 3));
    b.rect_x    = COORD_W'($urandom_range(0, 65535));
    b.rect_y    = COORD_W'($urandom_range(0, 65535));
    b.rect_w    = COL_W'($urandom_range(0, 1024));
    b.rect_h    = ROW_W'($urandom_range(0, 512));
    b.dest_x    = COORD_W'($urandom_range(0, 65535));
    b.dest_y    = COORD_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 7))
      0:       b.pixel_in = 16'hFFFF;
      1:       b.pixel_in = 16'h0000;
      default: b.pixel_in = PIX_W'($urandom_range(0, 65535));
    endcase
    return b;
  endfunction

  function automatic in_item_t step_beat();
    in_item_t b;
    b           = random_beat();
    b.operation = OP_STEP;
    return b;
  endfunction

  function automatic in_item_t pixel_beat(input logic [PIX_W-1:0] pix);
    in_item_t b;
    b          = step_beat();
    b.pixel_in = pix;
    return b;
  endfunction

  function automatic in_item_t start_beat(input op_e op, input int x, input int y,
                                          input int w, input int h, input int dx, input int dy);
    in_item_t b;
    b           = random_beat();
    b.operation = op;
    b.rect_x    = x[15:0];
    b.rect_y    = y[15:0];
    b.rect_w    = w[COL_W-1:0];
    b.rect_h    = h[ROW_W-1:0];
    b.dest_x    = dx[15:0];
    b.dest_y    = dy[15:0];
    return b;
  endfunction

  // most coordinates land in a small corner patch so transfers overlap and reuse pixels
  function automatic logic [15:0] pick_coord(input int extent);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom_range(0, 15);
      6:                v = extent - int'($urandom_range(1, 10));
      7:                v = -int'($urandom_range(1, 8));
      8:                v = $urandom_range(0, 65535);
      default:          v = $urandom_range(0, extent - 1);
    endcase
    return v[15:0];
  endfunction

  task automatic run_transfer();
    in_item_t    beat;
    int unsigned shape, trim, steps;
    beat = random_beat();
    case ($urandom_range(0, 2))
      0:       beat.operation = OP_LOAD;
      1:       beat.operation = OP_STORE;
      default: beat.operation = OP_MOVE;
    endcase
    beat.rect_x = pick_coord(STORE_WIDTH);
    beat.rect_y = pick_coord(STORE_HEIGHT);
    beat.dest_x = pick_coord(STORE_WIDTH);
    beat.dest_y = pick_coord(STORE_HEIGHT);
    shape = $urandom_range(0, 99);
    if (shape < 5) begin
      if ($urandom_range(0, 1) == 0) beat.rect_w = '0;
      else beat.rect_h = '0;
    end else if (shape >= 8) begin
      beat.rect_w = COL_W'($urandom_range(1, 8));
      beat.rect_h = ROW_W'($urandom_range(1, 4));
    end
    steps = int'(beat.rect_w) * int'(beat.rect_h);
    trim  = $urandom_range(0, 99);
    // large rectangles are only opened and walked a little, then abandoned
    if (shape >= 5 && shape < 8) steps = $urandom_range(1, 16);
    else if (steps != 0 && trim < 8) steps = $urandom_range(0, steps - 1);
    else if (trim < 14) steps += $urandom_range(1, 3);
    send_beat(beat);
    repeat (steps) send_beat(step_beat());
  endtask

  task automatic run_directed();
    send_beat(step_beat());
    send_beat(start_beat(OP_LOAD, 0, 0, 2, 2, 0, 0));
    send_beat(pixel_beat(16'hFFFF));
    send_beat(pixel_beat(16'h0000));
    send_beat(pixel_beat(16'h8000));
    send_beat(pixel_beat(16'h7FFF));
    send_beat(start_beat(OP_STORE, 0, 0, 2, 2, 0, 0));
    repeat (4) send_beat(step_beat());
    // overlapping move: second step reads the pixel the first one wrote
    send_beat(start_beat(OP_MOVE, 0, 0, 2, 1, 1, 0));
    repeat (2) send_beat(step_beat());
    send_beat(start_beat(OP_LOAD, 5, 5, 0, 3, 0, 0));
    send_beat(start_beat(OP_STORE, 5, 5, 5, 0, 0, 0));
    send_beat(start_beat(OP_LOAD, -32768, 32767, 1024, 512, -32768, 32767));
    send_beat(pixel_beat(16'hFFFF));
    send_beat(pixel_beat(16'h5555));
    // abandons the open load
    send_beat(start_beat(OP_STORE, 32767, -32768, 1023, 511, 32767, -32768));
    send_beat(step_beat());
    send_beat(start_beat(OP_MOVE, -32768, -32768, 1, 1, 32767, 32767));
    send_beat(step_beat());
    send_beat(step_beat());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    drain();
    while (items_done < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 88) run_transfer();
      else send_beat(random_beat());
      if ($urandom_range(0, 299) == 0) drain();
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      $error("%0d result beats never arrived", sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== vram_rect_transfer_engine.f =====
design/vrte_pkg.sv
design/vrte_pixel_ram.sv
design/vrte_walker.sv
design/vram_rect_transfer_engine.sv
bench/tb_vram_rect_transfer_engine.sv
